FILE: sv/circle_pair_collision_defines.svh
// Assertion macros shared by the circle pair collision RTL.
`ifndef CIRCLE_PAIR_COLLISION_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_DEFINES_SVH

// Plain property checked at every rising clock edge outside reset.
`define CCOL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define CCOL_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/ccol_pkg.sv
// Package with widths and transfer types of the circle pair collision block.
`timescale 1ns / 1ps
package ccol_pkg;

    localparam int COORD_BITS  = 20;
    localparam int RADIUS_BITS = COORD_BITS - 2;
    localparam int SUM_BITS    = COORD_BITS - 1;
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  first_x;
        logic signed [COORD_BITS-1:0]  first_y;
        logic        [RADIUS_BITS-1:0] first_radius;
        logic signed [COORD_BITS-1:0]  second_x;
        logic signed [COORD_BITS-1:0]  second_y;
        logic        [RADIUS_BITS-1:0] second_radius;
    } ccol_in_t;

    typedef struct packed {
        logic                         overlapping;
        logic signed [COORD_BITS-1:0] push_x;
        logic signed [COORD_BITS-1:0] push_y;
        logic                         centres_coincide;
    } ccol_out_t;

    typedef struct packed {
        logic                near;
        logic                coincide;
        logic                sx;
        logic                sy;
        logic [SUM_BITS-1:0] ax;
        logic [SUM_BITS-1:0] ay;
        logic [SUM_BITS-1:0] rsum;
    } ccol_item_t;

endpackage

FILE: sv/ccol_fifo.sv
// Small flip-flop queue used between the front, the back and the result port.
`timescale 1ns / 1ps
`include "circle_pair_collision_defines.svh"
module ccol_fifo
    import ccol_pkg::*;
#(
    parameter int  DEPTH  = MID_DEPTH,
    parameter type item_t = ccol_item_t
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    output logic  full,
    input  logic  pop,
    output item_t rdata,
    output logic  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `CCOL_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "queue count exceeds depth")
    `CCOL_IMPLY(a_pop_moves, do_pop && !do_push, ##1 count_reg == $past(count_reg) - 1'b1,
        "pop without push did not lower the count")

endmodule

FILE: sv/ccol_front.sv
// Front stage: takes circle pairs and reduces them to offsets and a radius sum.
`timescale 1ns / 1ps
module ccol_front
    import ccol_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ccol_in_t   pair,
    output logic       full,
    output ccol_item_t item,
    output logic       item_push,
    input  logic       item_full
);

    logic                   valid_reg, valid_next;
    ccol_item_t             item_reg, item_next;
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]    ndx;
    logic [COORD_BITS:0]    ndy;
    logic [COORD_BITS-1:0]  ax;
    logic [COORD_BITS-1:0]  ay;
    logic [SUM_BITS-1:0]    rsum;
    logic                   take;

    assign full      = valid_reg && item_full;
    assign take      = push && !full;
    assign item_push = valid_reg && !item_full;
    assign item      = item_reg;

    always_comb
    begin
        dx   = {pair.first_x[COORD_BITS-1], pair.first_x}
             - {pair.second_x[COORD_BITS-1], pair.second_x};
        dy   = {pair.first_y[COORD_BITS-1], pair.first_y}
             - {pair.second_y[COORD_BITS-1], pair.second_y};
        ndx  = -dx;
        ndy  = -dy;
        ax   = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ay   = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        rsum = {1'b0, pair.first_radius} + {1'b0, pair.second_radius};
        item_next.near     = (ax <= {1'b0, rsum}) && (ay <= {1'b0, rsum});
        item_next.coincide = (dx == '0) && (dy == '0);
        item_next.sx       = dx[COORD_BITS];
        item_next.sy       = dy[COORD_BITS];
        item_next.ax       = ax[SUM_BITS-1:0];
        item_next.ay       = ay[SUM_BITS-1:0];
        item_next.rsum     = rsum;
        valid_next         = take || (valid_reg && item_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: sv/ccol_back.sv
// Back pipeline: overlap test, square root, scaling and division per axis.
`timescale 1ns / 1ps
`include "circle_pair_collision_defines.svh"
module ccol_back
    import ccol_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ccol_item_t item,
    input  logic       item_valid,
    output logic       item_take,
    output ccol_out_t  res,
    output logic       res_valid,
    input  logic       res_ready
);

    localparam int S     = SUM_BITS;
    localparam int N     = 2 * S + 3;
    localparam int SQ0   = 2;
    localparam int MUL   = S + 2;
    localparam int DIV0  = S + 3;

    typedef struct packed {
        logic           overlap;
        logic           coincide;
        logic           sx;
        logic           sy;
        logic [S-1:0]   ax;
        logic [S-1:0]   ay;
        logic [S-1:0]   rsum;
        logic [2*S-1:0] sqx;
        logic [2*S-1:0] sqy;
        logic [2*S-1:0] sqr;
        logic [2*S-1:0] rad;
        logic [S+2:0]   rem;
        logic [S-1:0]   root;
        logic [2*S-1:0] nx;
        logic [2*S-1:0] ny;
        logic [S:0]     rx;
        logic [S:0]     ry;
        logic [S-1:0]   qx;
        logic [S-1:0]   qy;
    } ccol_pipe_t;

    ccol_pipe_t stage_reg [N];
    ccol_pipe_t stage_next [N];
    logic       vld_reg [N];
    logic       adv;

    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic                  show;

    assign adv       = !vld_reg[N-1] || res_ready;
    assign item_take = adv && item_valid;
    assign res_valid = vld_reg[N-1];

    always_comb
    begin
        stage_next[0]          = '0;
        stage_next[0].overlap  = item.near;
        stage_next[0].coincide = item.coincide;
        stage_next[0].sx       = item.sx;
        stage_next[0].sy       = item.sy;
        stage_next[0].ax       = item.ax;
        stage_next[0].ay       = item.ay;
        stage_next[0].rsum     = item.rsum;
        stage_next[0].sqx      = (2*S)'(item.ax * item.ax);
        stage_next[0].sqy      = (2*S)'(item.ay * item.ay);
        stage_next[0].sqr      = (2*S)'(item.rsum * item.rsum);
    end

    logic [2*S:0] d2;
    always_comb
    begin
        stage_next[1]         = stage_reg[0];
        d2                    = {1'b0, stage_reg[0].sqx} + {1'b0, stage_reg[0].sqy};
        stage_next[1].overlap = stage_reg[0].overlap && (d2 <= {1'b0, stage_reg[0].sqr});
        stage_next[1].rad     = d2[2*S-1:0];
        stage_next[1].rem     = '0;
        stage_next[1].root    = '0;
    end

    for (genvar g = SQ0; g < MUL; g++)
    begin : g_sqrt
        logic [S+2:0] rs;
        logic [S+2:0] tr;
        always_comb
        begin
            stage_next[g]     = stage_reg[g-1];
            rs                = {stage_reg[g-1].rem[S:0], stage_reg[g-1].rad[2*S-1 -: 2]};
            tr                = {1'b0, stage_reg[g-1].root, 2'b01};
            stage_next[g].rad = {stage_reg[g-1].rad[2*S-3:0], 2'b00};
            if (rs >= tr)
            begin
                stage_next[g].rem  = rs - tr;
                stage_next[g].root = {stage_reg[g-1].root[S-2:0], 1'b1};
            end
            else
            begin
                stage_next[g].rem  = rs;
                stage_next[g].root = {stage_reg[g-1].root[S-2:0], 1'b0};
            end
        end
    end

    logic [S-1:0]   pen;
    logic [2*S-1:0] prod_x;
    logic [2*S-1:0] prod_y;
    always_comb
    begin
        stage_next[MUL]    = stage_reg[MUL-1];
        pen                = stage_reg[MUL-1].rsum - stage_reg[MUL-1].root;
        prod_x             = (2*S)'(stage_reg[MUL-1].ax * pen);
        prod_y             = (2*S)'(stage_reg[MUL-1].ay * pen);
        stage_next[MUL].rx = {1'b0, prod_x[2*S-1:S]};
        stage_next[MUL].ry = {1'b0, prod_y[2*S-1:S]};
        stage_next[MUL].nx = {prod_x[S-1:0], {S{1'b0}}};
        stage_next[MUL].ny = {prod_y[S-1:0], {S{1'b0}}};
    end

    for (genvar g = DIV0; g < N; g++)
    begin : g_div
        logic [S:0] tx;
        logic [S:0] ty;
        logic [S:0] dv;
        always_comb
        begin
            stage_next[g]    = stage_reg[g-1];
            tx               = {stage_reg[g-1].rx[S-1:0], stage_reg[g-1].nx[2*S-1]};
            ty               = {stage_reg[g-1].ry[S-1:0], stage_reg[g-1].ny[2*S-1]};
            dv               = {1'b0, stage_reg[g-1].root};
            stage_next[g].nx = {stage_reg[g-1].nx[2*S-2:0], 1'b0};
            stage_next[g].ny = {stage_reg[g-1].ny[2*S-2:0], 1'b0};
            if (tx >= dv)
            begin
                stage_next[g].rx = tx - dv;
                stage_next[g].qx = {stage_reg[g-1].qx[S-2:0], 1'b1};
            end
            else
            begin
                stage_next[g].rx = tx;
                stage_next[g].qx = {stage_reg[g-1].qx[S-2:0], 1'b0};
            end
            if (ty >= dv)
            begin
                stage_next[g].ry = ty - dv;
                stage_next[g].qy = {stage_reg[g-1].qy[S-2:0], 1'b1};
            end
            else
            begin
                stage_next[g].ry = ty;
                stage_next[g].qy = {stage_reg[g-1].qy[S-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        show  = stage_reg[N-1].overlap && !stage_reg[N-1].coincide;
        mag_x = COORD_BITS'({1'b0, stage_reg[N-1].qx});
        mag_y = COORD_BITS'({1'b0, stage_reg[N-1].qy});
        res.overlapping      = stage_reg[N-1].overlap;
        res.centres_coincide = stage_reg[N-1].coincide;
        res.push_x = !show ? '0 : (stage_reg[N-1].sx ? -mag_x : mag_x);
        res.push_y = !show ? '0 : (stage_reg[N-1].sy ? -mag_y : mag_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i < N; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    `CCOL_IMPLY(a_coincide_zero, res_valid && res.centres_coincide,
        res.overlapping && res.push_x == '0 && res.push_y == '0,
        "coincident centres must overlap with zero separation")
    `CCOL_IMPLY(a_apart_zero, res_valid && !res.overlapping,
        res.push_x == '0 && res.push_y == '0, "separate circles must give zero separation")
    `CCOL_IMPLY(a_stall_hold, res_valid && !res_ready, ##1 res_valid && $stable(res),
        "stalled result changed")

endmodule

FILE: sv/circle_pair_collision.sv
// Circle pair collision test: overlap flag and separation vector per pair.
//
// Pairs enter through a queue-style port: a transfer happens on a clock edge
// with push high and full low. Results leave the same way: while empty is low
// the oldest result is on the result port, and pop with empty low takes it.
// One result comes out for every pair, in order.
// A pair's result becomes visible after it passes the front register, the
// classification queue, squares, overlap test, 19 square root stages, the
// penetration multiply, 19 division stages with both axes in parallel and
// the result queue.
// One pair per cycle is taken in steady state while the receiver keeps popping.
// When the receiver stops popping, the two-entry result queue fills, the back
// pipeline freezes, the four-entry middle queue fills, and full then rises.
// Reset clears all queues and valid bits; no pair is lost after reset.
`timescale 1ns / 1ps
module circle_pair_collision
    import ccol_pkg::*;
#(
    parameter int MID_QUEUE = MID_DEPTH,
    parameter int OUT_QUEUE = OUT_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ccol_in_t  pair,
    output logic      full,
    input  logic      pop,
    output ccol_out_t result,
    output logic      empty
);

    ccol_item_t fr_item;
    logic       fr_push;
    logic       mid_full;
    ccol_item_t mid_item;
    logic       mid_empty;
    logic       bk_take;
    ccol_out_t  bk_res;
    logic       bk_valid;
    logic       out_full;

    ccol_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pair      (pair),
        .full      (full),
        .item      (fr_item),
        .item_push (fr_push),
        .item_full (mid_full)
    );

    ccol_fifo #(
        .DEPTH  (MID_QUEUE),
        .item_t (ccol_item_t)
    ) u_mid (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_push),
        .wdata (fr_item),
        .full  (mid_full),
        .pop   (bk_take),
        .rdata (mid_item),
        .empty (mid_empty)
    );

    ccol_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_item),
        .item_valid (!mid_empty),
        .item_take  (bk_take),
        .res        (bk_res),
        .res_valid  (bk_valid),
        .res_ready  (!out_full)
    );

    ccol_fifo #(
        .DEPTH  (OUT_QUEUE),
        .item_t (ccol_out_t)
    ) u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_valid),
        .wdata (bk_res),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule
